@@ hw/rtl/hcwp_pkg.sv @@
// hcwp_pkg: shared types and constants for the host command word protocol unit
// no dependencies
package hcwp_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned FLAG_W = 4;

    localparam logic [WORD_W-1:0] ACK_WORD      = 16'h00FF;
    localparam logic [WORD_W-1:0] CMD_NOP       = 16'd0;
    localparam logic [WORD_W-1:0] CMD_READ      = 16'd1;
    localparam logic [WORD_W-1:0] CMD_WRITE     = 16'd2;
    localparam logic [WORD_W-1:0] CMD_TURN_ON   = 16'd3;
    localparam logic [WORD_W-1:0] CMD_TURN_OFF  = 16'd4;
    localparam logic [WORD_W-1:0] CMD_TRACK_ON  = 16'd5;
    localparam logic [WORD_W-1:0] CMD_TRACK_OFF = 16'd6;

    localparam logic [WORD_W-1:0] IDX_MODE     = 16'd0;
    localparam logic [WORD_W-1:0] IDX_SETPOINT = 16'd1;
    localparam logic [WORD_W-1:0] IDX_VOLTAGE  = 16'd0;
    localparam logic [WORD_W-1:0] IDX_CURRENT  = 16'd1;
    localparam logic [WORD_W-1:0] IDX_BOOST    = 16'd2;
    localparam logic [WORD_W-1:0] IDX_POWER    = 16'd3;
    localparam logic [WORD_W-1:0] IDX_STATUS   = 16'd4;

    localparam logic [WORD_W-1:0] MODE_RESET     = 16'd5;
    localparam logic [WORD_W-1:0] SETPOINT_RESET = 16'd6;
    localparam logic [FLAG_W-1:0] ON_RESET       = 4'd7;
    localparam logic [FLAG_W-1:0] OFF_RESET      = 4'd8;
    localparam logic [FLAG_W-1:0] TRACK_RESET    = 4'd9;
    localparam logic [FLAG_W-1:0] FLAG_SET       = 4'd1;
    localparam logic [FLAG_W-1:0] TRACK_AUTO     = 4'd2;
    localparam logic [FLAG_W-1:0] TRACK_FIXED    = 4'd1;

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_INDEX  = 3'd1,
        PH_WDATA  = 3'd2,
        PH_RINDEX = 3'd3,
        PH_CLOSE  = 3'd4
    } t_phase;

endpackage

@@ hw/rtl/host_command_word_protocol_unit.sv @@
// host_command_word_protocol_unit: slave-side command word handler, top level
// depends on hcwp_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one received link word
//   plus five live telemetry values per transaction
//   output channel (o_out_valid / i_out_ready) carries one result transaction
//   per input transaction: tx flag and word, plus the settings, flags and
//   error count as they stand after that input
// result: registered; o_out_valid rises in the cycle after input acceptance
// throughput: one transaction per cycle unless stalled, set by the single
//   protocol state update between the input handshake and the result register
// stall: while a result waits and i_out_ready is low, o_in_ready is low;
//   when the result is taken in the same cycle, a new input is accepted
// reset: synchronous, active low; handler waits for a command, mode = 5,
//   setpoint = 6, on flag = 7, off flag = 8, tracker flag = 9, errors = 0,
//   no result pending
//
module host_command_word_protocol_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hcwp_pkg::WORD_W-1:0] i_rx_word,
    input  logic signed [hcwp_pkg::WORD_W-1:0] i_panel_voltage,
    input  logic signed [hcwp_pkg::WORD_W-1:0] i_panel_current,
    input  logic signed [hcwp_pkg::WORD_W-1:0] i_boost_voltage,
    input  logic signed [hcwp_pkg::WORD_W-1:0] i_panel_power,
    input  logic signed [hcwp_pkg::WORD_W-1:0] i_tracker_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_tx_valid,
    output logic [hcwp_pkg::WORD_W-1:0] o_tx_word,
    output logic [hcwp_pkg::WORD_W-1:0] o_system_mode,
    output logic [hcwp_pkg::WORD_W-1:0] o_converter_setpoint,
    output logic [hcwp_pkg::FLAG_W-1:0] o_turn_on_request,
    output logic [hcwp_pkg::FLAG_W-1:0] o_turn_off_request,
    output logic [hcwp_pkg::FLAG_W-1:0] o_tracker_mode,
    output logic [hcwp_pkg::WORD_W-1:0] o_error_count
);
    import hcwp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [WORD_W-1:0]   r_held_command, n_held_command;
    logic [WORD_W-1:0]   r_held_index, n_held_index;
    logic [WORD_W-1:0]   r_mode, n_mode;
    logic [WORD_W-1:0]   r_setpoint, n_setpoint;
    logic [FLAG_W-1:0]   r_on, n_on;
    logic [FLAG_W-1:0]   r_off, n_off;
    logic [FLAG_W-1:0]   r_track, n_track;
    logic [WORD_W-1:0]   r_errors, n_errors;

    logic                r_out_valid;
    logic                r_tx_valid, n_tx_valid;
    logic [WORD_W-1:0]   r_tx_word, n_tx_word;

    logic                w_accept;
    logic [WORD_W-1:0]   w_telemetry;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        case (r_held_index)
            IDX_VOLTAGE: w_telemetry = i_panel_voltage;
            IDX_CURRENT: w_telemetry = i_panel_current;
            IDX_BOOST:   w_telemetry = i_boost_voltage;
            IDX_POWER:   w_telemetry = i_panel_power;
            IDX_STATUS:  w_telemetry = i_tracker_status;
            default:     w_telemetry = i_rx_word;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_held_command = r_held_command;
        n_held_index   = r_held_index;
        n_mode         = r_mode;
        n_setpoint     = r_setpoint;
        n_on           = r_on;
        n_off          = r_off;
        n_track        = r_track;
        n_errors       = r_errors;
        n_tx_valid     = 1'b0;
        n_tx_word      = '0;
        case (r_phase)
            PH_INDEX: begin
                n_tx_valid   = 1'b1;
                n_tx_word    = i_rx_word;
                n_held_index = i_rx_word;
                if (r_held_command == CMD_READ) begin
                    n_phase = PH_RINDEX;
                end else if (r_held_command == CMD_WRITE) begin
                    n_phase = PH_WDATA;
                end else begin
                    n_phase        = PH_CMD;
                    n_held_command = '0;
                    n_held_index   = '0;
                end
            end
            PH_WDATA: begin
                if (r_held_index == IDX_MODE) begin
                    n_mode = i_rx_word;
                end else if (r_held_index == IDX_SETPOINT) begin
                    n_setpoint = i_rx_word;
                end
                n_tx_valid     = 1'b1;
                n_tx_word      = ACK_WORD;
                n_phase        = PH_CMD;
                n_held_command = '0;
                n_held_index   = '0;
            end
            PH_RINDEX: begin
                if (i_rx_word == r_held_index) begin
                    n_tx_valid = 1'b1;
                    n_tx_word  = w_telemetry;
                    n_phase    = PH_CLOSE;
                end else begin
                    n_errors       = r_errors + 1'b1;
                    n_phase        = PH_CMD;
                    n_held_command = '0;
                    n_held_index   = '0;
                end
            end
            PH_CLOSE: begin
                if (i_rx_word != ACK_WORD) begin
                    n_errors = r_errors + 1'b1;
                end
                n_phase        = PH_CMD;
                n_held_command = '0;
                n_held_index   = '0;
            end
            default: begin
                n_tx_valid     = 1'b1;
                n_tx_word      = i_rx_word;
                n_held_command = i_rx_word;
                if (i_rx_word <= CMD_WRITE) begin
                    n_phase = PH_INDEX;
                end else begin
                    if (i_rx_word == CMD_TURN_ON) begin
                        n_on = FLAG_SET;
                    end else if (i_rx_word == CMD_TURN_OFF) begin
                        n_off = FLAG_SET;
                    end else if (i_rx_word == CMD_TRACK_ON) begin
                        n_track = TRACK_AUTO;
                    end else if (i_rx_word == CMD_TRACK_OFF) begin
                        n_track = TRACK_FIXED;
                    end
                    n_phase        = PH_CMD;
                    n_held_command = '0;
                    n_held_index   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CMD;
            r_held_command <= '0;
            r_held_index   <= '0;
            r_mode         <= MODE_RESET;
            r_setpoint     <= SETPOINT_RESET;
            r_on           <= ON_RESET;
            r_off          <= OFF_RESET;
            r_track        <= TRACK_RESET;
            r_errors       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_held_command <= n_held_command;
                r_held_index   <= n_held_index;
                r_mode         <= n_mode;
                r_setpoint     <= n_setpoint;
                r_on           <= n_on;
                r_off          <= n_off;
                r_track        <= n_track;
                r_errors       <= n_errors;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx_valid <= n_tx_valid;
            r_tx_word  <= n_tx_word;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_tx_valid           = r_tx_valid;
    assign o_tx_word            = r_tx_word;
    assign o_system_mode        = r_mode;
    assign o_converter_setpoint = r_setpoint;
    assign o_turn_on_request    = r_on;
    assign o_turn_off_request   = r_off;
    assign o_tracker_mode       = r_track;
    assign o_error_count        = r_errors;

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for host_command_word_protocol_unit, directed and random link
// word exchanges with random idle gaps on both channels, every reply checked in order
// depends on hcwp_pkg and host_command_word_protocol_unit
module tb;
    import hcwp_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]      rx_word;
        logic [4:0][WORD_W-1:0] readings;
    } t_link_word;

    typedef struct packed {
        logic              tx_valid;
        logic [WORD_W-1:0] tx_word;
        logic [WORD_W-1:0] system_mode;
        logic [WORD_W-1:0] converter_setpoint;
        logic [FLAG_W-1:0] turn_on_request;
        logic [FLAG_W-1:0] turn_off_request;
        logic [FLAG_W-1:0] tracker_mode;
        logic [WORD_W-1:0] error_count;
    } t_link_reply;

    class exchange_checker;
        t_phase            phase;
        logic [WORD_W-1:0] held_command;
        logic [WORD_W-1:0] held_index;
        logic [WORD_W-1:0] mode_value;
        logic [WORD_W-1:0] setpoint_value;
        logic [WORD_W-1:0] error_total;
        logic [FLAG_W-1:0] on_flag;
        logic [FLAG_W-1:0] off_flag;
        logic [FLAG_W-1:0] tracker_flag;
        t_link_reply       awaited_replies[$];
        int                failures;

        function new();
            go_idle();
            mode_value     = MODE_RESET;
            setpoint_value = SETPOINT_RESET;
            on_flag        = ON_RESET;
            off_flag       = OFF_RESET;
            tracker_flag   = TRACK_RESET;
            error_total    = '0;
            failures       = 0;
        endfunction

        function void go_idle();
            phase        = PH_CMD;
            held_command = '0;
            held_index   = '0;
        endfunction

        function void link_fault();
            error_total = error_total + 1'b1;
            go_idle();
        endfunction

        function t_link_reply step_handler(t_link_word item);
            t_link_reply r;
            r = '0;
            case (phase)
                PH_INDEX: begin
                    r.tx_valid = 1'b1;
                    r.tx_word  = item.rx_word;
                    held_index = item.rx_word;
                    if (held_command == CMD_READ) begin
                        phase = PH_RINDEX;
                    end else if (held_command == CMD_WRITE) begin
                        phase = PH_WDATA;
                    end else begin
                        go_idle();
                    end
                end
                PH_WDATA: begin
                    if (held_index == IDX_MODE) begin
                        mode_value = item.rx_word;
                    end else if (held_index == IDX_SETPOINT) begin
                        setpoint_value = item.rx_word;
                    end
                    r.tx_valid = 1'b1;
                    r.tx_word  = ACK_WORD;
                    go_idle();
                end
                PH_RINDEX: begin
                    if (item.rx_word == held_index) begin
                        r.tx_valid = 1'b1;
                        if (held_index <= IDX_STATUS) begin
                            r.tx_word = item.readings[held_index[2:0]];
                        end else begin
                            r.tx_word = item.rx_word;
                        end
                        phase = PH_CLOSE;
                    end else begin
                        link_fault();
                    end
                end
                PH_CLOSE: begin
                    if (item.rx_word == ACK_WORD) begin
                        go_idle();
                    end else begin
                        link_fault();
                    end
                end
                default: begin
                    r.tx_valid   = 1'b1;
                    r.tx_word    = item.rx_word;
                    held_command = item.rx_word;
                    if (item.rx_word <= CMD_WRITE) begin
                        phase = PH_INDEX;
                    end else begin
                        if (item.rx_word == CMD_TURN_ON) begin
                            on_flag = FLAG_SET;
                        end else if (item.rx_word == CMD_TURN_OFF) begin
                            off_flag = FLAG_SET;
                        end else if (item.rx_word == CMD_TRACK_ON) begin
                            tracker_flag = TRACK_AUTO;
                        end else if (item.rx_word == CMD_TRACK_OFF) begin
                            tracker_flag = TRACK_FIXED;
                        end
                        go_idle();
                    end
                end
            endcase
            r.system_mode        = mode_value;
            r.converter_setpoint = setpoint_value;
            r.turn_on_request    = on_flag;
            r.turn_off_request   = off_flag;
            r.tracker_mode       = tracker_flag;
            r.error_count        = error_total;
            return r;
        endfunction

        function void record_word(t_link_word item);
            awaited_replies.push_back(step_handler(item));
        endfunction

        function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", field, want, got);
                failures++;
            end
        endfunction

        function void check_reply(t_link_reply got);
            t_link_reply want;
            if (awaited_replies.size() == 0) begin
                $error("reply with none awaited: tx_word %h", got.tx_word);
                failures++;
                return;
            end
            want = awaited_replies.pop_front();
            compare("tx_valid", WORD_W'(want.tx_valid), WORD_W'(got.tx_valid));
            compare("tx_word", want.tx_word, got.tx_word);
            compare("system_mode", want.system_mode, got.system_mode);
            compare("converter_setpoint", want.converter_setpoint, got.converter_setpoint);
            compare("turn_on_request", WORD_W'(want.turn_on_request),
                WORD_W'(got.turn_on_request));
            compare("turn_off_request", WORD_W'(want.turn_off_request),
                WORD_W'(got.turn_off_request));
            compare("tracker_mode", WORD_W'(want.tracker_mode), WORD_W'(got.tracker_mode));
            compare("error_count", want.error_count, got.error_count);
        endfunction
    endclass

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_ready;
    logic [WORD_W-1:0]        i_rx_word        = '0;
    logic signed [WORD_W-1:0] i_panel_voltage  = '0;
    logic signed [WORD_W-1:0] i_panel_current  = '0;
    logic signed [WORD_W-1:0] i_boost_voltage  = '0;
    logic signed [WORD_W-1:0] i_panel_power    = '0;
    logic signed [WORD_W-1:0] i_tracker_status = '0;
    logic                     o_out_valid;
    logic                     i_out_ready      = 1'b0;
    logic                     o_tx_valid;
    logic [WORD_W-1:0]        o_tx_word;
    logic [WORD_W-1:0]        o_system_mode;
    logic [WORD_W-1:0]        o_converter_setpoint;
    logic [FLAG_W-1:0]        o_turn_on_request;
    logic [FLAG_W-1:0]        o_turn_off_request;
    logic [FLAG_W-1:0]        o_tracker_mode;
    logic [WORD_W-1:0]        o_error_count;

    exchange_checker link_check;
    bit              no_idling  = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     words_sent = 0;

    host_command_word_protocol_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_rx_word            (i_rx_word),
        .i_panel_voltage      (i_panel_voltage),
        .i_panel_current      (i_panel_current),
        .i_boost_voltage      (i_boost_voltage),
        .i_panel_power        (i_panel_power),
        .i_tracker_status     (i_tracker_status),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_tx_valid           (o_tx_valid),
        .o_tx_word            (o_tx_word),
        .o_system_mode        (o_system_mode),
        .o_converter_setpoint (o_converter_setpoint),
        .o_turn_on_request    (o_turn_on_request),
        .o_turn_off_request   (o_turn_off_request),
        .o_tracker_mode       (o_tracker_mode),
        .o_error_count        (o_error_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom_range(0, 16'hFFFF));
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] pick_reading();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return random_word();
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            link_check.check_reply('{o_tx_valid, o_tx_word, o_system_mode,
                o_converter_setpoint, o_turn_on_request, o_turn_off_request,
                o_tracker_mode, o_error_count});
        end
        if (no_idling) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = idle_length() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] rx);
        t_link_word  item;
        int unsigned gap;
        item.rx_word = rx;
        for (int i = 0; i < 5; i++) begin
            item.readings[i] = pick_reading();
        end
        gap = (no_idling || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_rx_word        <= rx;
        i_panel_voltage  <= item.readings[0];
        i_panel_current  <= item.readings[1];
        i_boost_voltage  <= item.readings[2];
        i_panel_power    <= item.readings[3];
        i_tracker_status <= item.readings[4];
        do @(posedge i_clk); while (!o_in_ready);
        link_check.record_word(item);
        words_sent++;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (link_check.awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_exchange();
        logic [WORD_W-1:0] idx;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                if ($urandom_range(0, 5) != 0) idx = WORD_W'($urandom_range(0, 4));
                else idx = random_word();
                send_word(CMD_READ);
                send_word(idx);
                send_word(idx);
                send_word(ACK_WORD);
            end
            3, 4: begin
                if ($urandom_range(0, 5) != 0) idx = WORD_W'($urandom_range(0, 1));
                else idx = random_word();
                send_word(CMD_WRITE);
                send_word(idx);
                send_word(random_word());
            end
            5: begin
                idx = WORD_W'($urandom_range(3, 6));
                send_word(idx);
            end
            6: begin
                send_word(CMD_NOP);
                send_word(random_word());
            end
            7: begin
                idx = WORD_W'($urandom_range(0, 4));
                send_word(CMD_READ);
                send_word(idx);
                if ($urandom_range(0, 1) == 0) begin
                    send_word(idx ^ (16'd1 << $urandom_range(0, 15)));
                end else begin
                    send_word(idx);
                    send_word(random_word());
                end
            end
            default: begin
                if ($urandom_range(0, 1) == 0) idx = WORD_W'($urandom_range(0, 8));
                else idx = random_word();
                send_word(idx);
            end
        endcase
    endtask

    initial begin
        link_check = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flag commands, unknown commands, no-op with its index
        send_word(CMD_TURN_ON);
        send_word(CMD_TURN_OFF);
        send_word(CMD_TRACK_ON);
        send_word(CMD_TRACK_OFF);
        send_word(16'd7);
        send_word(16'hFFFF);
        send_word(CMD_NOP);
        send_word(16'hFFFF);
        // writes: mode, setpoint, ignored index
        send_word(CMD_WRITE);
        send_word(IDX_MODE);
        send_word(16'hFFFF);
        send_word(CMD_WRITE);
        send_word(IDX_SETPOINT);
        send_word(16'h0000);
        send_word(CMD_WRITE);
        send_word(16'd7);
        send_word(16'h1234);
        // reads: good, index out of range, index mismatch, bad close
        send_word(CMD_READ);
        send_word(IDX_VOLTAGE);
        send_word(IDX_VOLTAGE);
        send_word(ACK_WORD);
        send_word(CMD_READ);
        send_word(16'd9);
        send_word(16'd9);
        send_word(ACK_WORD);
        send_word(CMD_READ);
        send_word(IDX_BOOST);
        send_word(IDX_POWER);
        send_word(CMD_READ);
        send_word(IDX_STATUS);
        send_word(IDX_STATUS);
        send_word(16'h0000);
        drain_replies();

        while (words_sent < 250) random_exchange();
        no_idling = 1'b1;
        while (words_sent < 400) random_exchange();
        no_idling = 1'b0;
        while (words_sent < 650) random_exchange();
        drain_replies();
        while (words_sent < 950) random_exchange();
        drain_replies();
        repeat (4) @(posedge i_clk);

        if (link_check.failures == 0) begin
            $display("host_command_word_protocol_unit: match");
        end else begin
            $display("host_command_word_protocol_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("host_command_word_protocol_unit: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hcwp_pkg.sv
hw/rtl/host_command_word_protocol_unit.sv
tb/tb.sv
